/* rtl/core/p2ts_pkg.sv */
// Types and constants shared by the PES to TS packetizer modules.
// No dependencies.
package p2ts_pkg;

   localparam int PAYLOAD_BYTES = 184;
   localparam int TS_BYTES      = 188;
   localparam int RAM_DEPTH     = 2 * PAYLOAD_BYTES;
   localparam int RAM_AW        = $clog2(RAM_DEPTH);

   localparam logic [7:0] SYNC_BYTE     = 8'h47;
   localparam logic [7:0] STUFF_BYTE    = 8'hFF;
   localparam logic [1:0] AFC_PAYLOAD   = 2'b01;
   localparam logic [1:0] AFC_ADAPT_PAY = 2'b11;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [12:0] packet_id;
      logic        stream_index;
   } req_type;

   typedef struct packed {
      logic [31:0] ts_word;
      logic        packet_end;
   } rsp_type;

   // One finished payload waiting in a RAM bank
   typedef struct packed {
      logic [7:0]  fill;
      logic [12:0] pid;
      logic [3:0]  cc;
      logic        pusi;
   } desc_type;

endpackage

/* rtl/core/p2ts_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module p2ts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 368
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/p2ts_front.sv */
// Front end: takes PES bytes, writes them into the current RAM bank and closes
// a packet when the bank is full or the last byte arrives. Uses p2ts_pkg.
module p2ts_front #(
   parameter int NUM_STREAMS = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  p2ts_pkg::req_type            req_data,
   input  logic                         q_full,
   output logic                         push,
   output p2ts_pkg::desc_type           push_desc,
   output logic                         wr_en,
   output logic [p2ts_pkg::RAM_AW-1:0]  wr_addr,
   output logic [7:0]                   wr_data
);
   import p2ts_pkg::*;

   localparam int SW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;

   logic [7:0]    fill_ff, fill_in, fill_next;
   logic          bank_ff, bank_in;
   logic          at_start_ff, at_start_in;
   logic [3:0]    cc_ff [NUM_STREAMS];
   logic [3:0]    cc_in [NUM_STREAMS];
   logic [SW-1:0] sidx;
   logic          accept, done;

   // bank is free whenever fewer than two packets are pending
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign fill_next = fill_ff + 8'd1;
   assign done      = accept && (fill_next == 8'(PAYLOAD_BYTES) || req_data.last_byte);
   assign sidx      = (NUM_STREAMS > 1) ? SW'(req_data.stream_index) : '0;

   assign wr_en   = accept;
   assign wr_data = req_data.data_byte;
   assign wr_addr = bank_ff ? RAM_AW'(fill_ff) + RAM_AW'(PAYLOAD_BYTES) : RAM_AW'(fill_ff);

   assign push           = done;
   assign push_desc.fill = fill_next;
   assign push_desc.pid  = req_data.packet_id;
   assign push_desc.cc   = cc_ff[sidx];
   assign push_desc.pusi = at_start_ff;

   always_comb begin
      fill_in     = fill_ff;
      bank_in     = bank_ff;
      at_start_in = at_start_ff;
      cc_in       = cc_ff;
      if (accept) begin
         fill_in = fill_next;
      end
      if (done) begin
         fill_in     = '0;
         bank_in     = ~bank_ff;
         at_start_in = req_data.last_byte;
         cc_in[sidx] = cc_ff[sidx] + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         bank_ff     <= 1'b0;
         at_start_ff <= 1'b1;
         for (int i = 0; i < NUM_STREAMS; i++) begin
            cc_ff[i] <= '0;
         end
      end else begin
         fill_ff     <= fill_in;
         bank_ff     <= bank_in;
         at_start_ff <= at_start_in;
         cc_ff       <= cc_in;
      end
   end

endmodule

/* rtl/core/p2ts_queue.sv */
// Two-entry packet queue between front and back; one entry per RAM bank.
// Uses p2ts_pkg.
module p2ts_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  p2ts_pkg::desc_type  push_desc,
   output logic                q_full,
   output logic                q_valid,
   output p2ts_pkg::desc_type  q_desc,
   input  logic                pop
);
   import p2ts_pkg::*;

   desc_type   ent_ff [2];
   logic       wp_ff, wp_in;
   logic       rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   assign q_full  = cnt_ff == 2'd2;
   assign q_valid = cnt_ff != 2'd0;
   assign q_desc  = ent_ff[rp_ff];

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wp_ff] <= push_desc;
      end
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

/* rtl/core/p2ts_back.sv */
// Back end: walks the 188 bytes of the head packet, reading payload from the
// RAM, and packs them into 32-bit words behind an output register. Uses p2ts_pkg.
module p2ts_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   input  p2ts_pkg::desc_type           q_desc,
   output logic                         pop,
   output logic                         rd_en,
   output logic [p2ts_pkg::RAM_AW-1:0]  rd_addr,
   input  logic [7:0]                   rd_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output p2ts_pkg::rsp_type            rsp_data
);
   import p2ts_pkg::*;

   logic [7:0]  pos_ff, pos_in;
   logic        rbank_ff, rbank_in;
   logic        b_valid_ff, b_sel_ff, b_end_ff;
   logic [1:0]  b_lo_ff;
   logic [7:0]  b_const_ff;
   logic [23:0] acc_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff;

   logic [7:0]  start, offset, const_byte, byte_b;
   logic        in_payload, is_short;
   logic        word_done, out_free, stall_b, issue;

   // payload always ends at byte 187, so it starts at 188 - fill
   assign start      = 8'(TS_BYTES) - q_desc.fill;
   assign in_payload = pos_ff >= start;
   assign offset     = pos_ff - start;
   assign is_short   = q_desc.fill != 8'(PAYLOAD_BYTES);

   always_comb begin
      if (pos_ff == 8'd0) begin
         const_byte = SYNC_BYTE;
      end else if (pos_ff == 8'd1) begin
         const_byte = {1'b0, q_desc.pusi, 1'b0, q_desc.pid[12:8]};
      end else if (pos_ff == 8'd2) begin
         const_byte = q_desc.pid[7:0];
      end else if (pos_ff == 8'd3) begin
         const_byte = {2'b00, is_short ? AFC_ADAPT_PAY : AFC_PAYLOAD, q_desc.cc};
      end else if (pos_ff == 8'd4) begin
         const_byte = 8'(PAYLOAD_BYTES - 1) - q_desc.fill;   // adaptation length
      end else if (pos_ff == 8'd5) begin
         const_byte = 8'h00;                                 // adaptation flags
      end else begin
         const_byte = STUFF_BYTE;
      end
   end

   assign byte_b    = b_sel_ff ? rd_data : b_const_ff;
   assign word_done = b_valid_ff && b_lo_ff == 2'd3;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign stall_b   = word_done && !out_free;
   assign issue     = q_valid && !stall_b;
   assign pop       = issue && pos_ff == 8'(TS_BYTES - 1);

   assign rd_en   = issue && in_payload;
   assign rd_addr = rbank_ff ? RAM_AW'(offset) + RAM_AW'(PAYLOAD_BYTES) : RAM_AW'(offset);

   always_comb begin
      pos_in   = pos_ff;
      rbank_in = rbank_ff;
      if (issue) begin
         pos_in = pos_ff + 8'd1;
      end
      if (pop) begin
         pos_in   = '0;
         rbank_in = ~rbank_ff;
      end
      rsp_valid_in = rsp_valid_ff;
      if (word_done && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         b_sel_ff   <= in_payload;
         b_const_ff <= const_byte;
         b_lo_ff    <= pos_ff[1:0];
         b_end_ff   <= pos_ff == 8'(TS_BYTES - 1);
      end
      if (b_valid_ff && !stall_b) begin
         acc_ff <= {acc_ff[15:0], byte_b};
      end
      if (word_done && out_free) begin
         rsp_data_ff.ts_word    <= {acc_ff, byte_b};
         rsp_data_ff.packet_end <= b_end_ff;
      end
      if (reset) begin
         pos_ff       <= '0;
         rbank_ff     <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         rbank_ff     <= rbank_in;
         b_valid_ff   <= issue || stall_b;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/core/pes_to_ts_packetizer.sv */
// PES to MPEG-2 TS packetizer. Takes one PES byte a cycle into a two-bank
// payload RAM (184 bytes a bank) while a bank is free; a packet closes when its
// bank fills or the last byte arrives. The back end then walks all 188 bytes of
// each packet, full or short, taking payload bytes from the RAM's single read
// port, one byte a cycle while a packet is queued and the output does not stall,
// and packs them into 32-bit words, 47 words a packet. Depends on p2ts_pkg and
// the p2ts_* modules.
module pes_to_ts_packetizer #(
   parameter int NUM_STREAMS = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  p2ts_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output p2ts_pkg::rsp_type  rsp_data
);
   import p2ts_pkg::*;

   logic              push, q_full, q_valid, pop;
   desc_type          push_desc, q_desc;
   logic              wr_en, rd_en;
   logic [RAM_AW-1:0] wr_addr, rd_addr;
   logic [7:0]        wr_data, rd_data;

   p2ts_front #(.NUM_STREAMS(NUM_STREAMS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .push      (push),
      .push_desc (push_desc),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   p2ts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .q_full    (q_full),
      .q_valid   (q_valid),
      .q_desc    (q_desc),
      .pop       (pop)
   );

   p2ts_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   p2ts_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_desc    (q_desc),
      .pop       (pop),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* tb/sv/pes_to_ts_packetizer_tb.sv */
// Self-checking testbench for pes_to_ts_packetizer: predicts every TS word from the
// accepted PES beats and checks the output words in order.
// Depends on p2ts_pkg and the packetizer RTL.
module pes_to_ts_packetizer_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import p2ts_pkg::*;

   localparam int NUM_STREAMS  = 2;
   localparam int TS_WORDS     = TS_BYTES / 4;
   localparam int HDR_BYTES    = TS_BYTES - PAYLOAD_BYTES;
   localparam int MAX_ALEN     = PAYLOAD_BYTES - 1;
   localparam int LIMIT_CYCLES = 3_000_000;
   localparam int DRAIN_CYCLES = 4 * TS_BYTES;
   localparam int HOLD_CYCLES  = 3000;
   localparam int HOLD_PES     = 8;
   localparam int HOLD_PES_LEN = 3;
   localparam int MAX_REPORTS  = 30;
   localparam int PHASE_BYTES  = 18;

   class ts_scoreboard;
      rsp_type    ts_words_due[$];
      logic [7:0] payload[PAYLOAD_BYTES];
      logic [3:0] cont_count[NUM_STREAMS];
      int         fill;
      bit         pes_start;
      int         errors;
      int         bytes_seen;
      int         words_seen;
      int         full_pkts;
      int         short_pkts;
      int         zero_alen_pkts;

      function new();
         foreach (cont_count[i]) cont_count[i] = '0;
         fill           = 0;
         pes_start      = 1'b1;
         errors         = 0;
         bytes_seen     = 0;
         words_seen     = 0;
         full_pkts      = 0;
         short_pkts     = 0;
         zero_alen_pkts = 0;
      endfunction

      task report_mismatch(string msg);
         errors++;
         // keep the log readable when the block is badly broken
         if (errors <= MAX_REPORTS) $display("[%0t] MISMATCH: %s", $time, msg);
      endtask

      // Accepted PES beat: buffer it and queue the 47 words of a packet if it closes one
      function void note_pes_byte(req_type b);
         logic [7:0] pkt[TS_BYTES];
         logic [3:0] cc;
         rsp_type    w;
         int         sid;
         int         alen;
         int         k;
         bytes_seen++;
         if (fill >= PAYLOAD_BYTES) fill = 0;
         payload[fill] = b.data_byte;
         fill++;
         if (fill >= PAYLOAD_BYTES || b.last_byte) begin
            // header fields come from the beat that closes the packet
            sid    = int'(b.stream_index) % NUM_STREAMS;
            cc     = cont_count[sid];
            pkt[0] = SYNC_BYTE;
            pkt[1] = {1'b0, pes_start, 1'b0, b.packet_id[12:8]};
            pkt[2] = b.packet_id[7:0];
            if (fill >= PAYLOAD_BYTES) begin
               pkt[3] = {2'b00, AFC_PAYLOAD, cc};
               for (k = 0; k < PAYLOAD_BYTES; k++) pkt[HDR_BYTES + k] = payload[k];
               full_pkts++;
            end else begin
               alen   = MAX_ALEN - fill;
               pkt[3] = {2'b00, AFC_ADAPT_PAY, cc};
               pkt[4] = 8'(alen);
               if (alen > 0) begin
                  pkt[5] = 8'h00;
                  for (k = 6; k < HDR_BYTES + 1 + alen; k++) pkt[k] = STUFF_BYTE;
               end else begin
                  zero_alen_pkts++;
               end
               for (k = 0; k < fill; k++) pkt[HDR_BYTES + 1 + alen + k] = payload[k];
               short_pkts++;
            end
            for (k = 0; k < TS_WORDS; k++) begin
               w.ts_word    = {pkt[4*k], pkt[4*k+1], pkt[4*k+2], pkt[4*k+3]};
               w.packet_end = (k == TS_WORDS - 1);
               ts_words_due.push_back(w);
            end
            cont_count[sid] = cc + 4'd1;
            fill            = 0;
            pes_start       = 1'b0;
         end
         if (b.last_byte) pes_start = 1'b1;
      endfunction

      task check_ts_word(rsp_type got);
         rsp_type want;
         words_seen++;
         if (ts_words_due.size() == 0) begin
            report_mismatch($sformatf("unexpected word %h end=%b", got.ts_word,
                                      got.packet_end));
            return;
         end
         want = ts_words_due.pop_front();
         if (got.ts_word !== want.ts_word)
            report_mismatch($sformatf("word %0d: ts_word %h, expected %h", words_seen,
                                      got.ts_word, want.ts_word));
         if (got.packet_end !== want.packet_end)
            report_mismatch($sformatf("word %0d: packet_end %b, expected %b", words_seen,
                                      got.packet_end, want.packet_end));
      endtask
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   ts_scoreboard sb = new();

   int send_idle_pct;
   int recv_stall_pct;
   int hold_cycles;
   int cycle_count;
   int input_stall_cycles;

   pes_to_ts_packetizer #(.NUM_STREAMS(NUM_STREAMS)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: random stalls, or a counted hold-off when one is requested
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall = 1'b1;
            hold_cycles--;
         end else begin
            rsp_stall = ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_pes_byte(req_data);
         if (req_valid && req_stall) input_stall_cycles++;
         if (rsp_valid && !rsp_stall) sb.check_ts_word(rsp_data);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles, %0d words still due", cycle_count,
                  sb.ts_words_due.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge after the beat is taken
   task automatic send_byte(logic [7:0] d, logic last, logic [12:0] pid, logic sidx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = {d, last, pid, sidx};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // scramble: PID and stream change on every beat of the PES
   task automatic send_pes(int len, logic [12:0] pid, logic sidx, bit scramble);
      for (int i = 0; i < len; i++) begin
         if (scramble) begin
            pid  = 13'($urandom_range(8191));
            sidx = 1'($urandom_range(1));
         end
         send_byte(8'($urandom_range(255)), (i == len - 1), pid, sidx);
      end
   endtask

   task automatic drain();
      while (sb.ts_words_due.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic run_random_phase(int idle, int stall, int n_bytes);
      int sent;
      int len;
      int r;
      send_idle_pct  = idle;
      recv_stall_pct = stall;
      sent           = 0;
      while (sent < n_bytes) begin
         r = $urandom_range(99);
         if (r < 80)      len = $urandom_range(1, 12);
         else if (r < 93) len = $urandom_range(13, 100);
         else if (r < 98) len = $urandom_range(PAYLOAD_BYTES - 9, PAYLOAD_BYTES + 6);
         else             len = $urandom_range(300, 380);
         // keep the phase to its byte budget
         if (len > n_bytes - sent) len = n_bytes - sent;
         send_pes(len, 13'($urandom_range(8191)), 1'($urandom_range(1)),
                  $urandom_range(9) == 0);
         sent += len;
      end
      drain();
   endtask

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_data           = '0;
      send_idle_pct      = 0;
      recv_stall_pct     = 0;
      hold_cycles        = 0;
      cycle_count        = 0;
      input_stall_cycles = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: field extremes, one-beat PES, mixed header fields
      send_byte(8'h00, 1'b1, 13'h0000, 1'b0);
      send_byte(8'hFF, 1'b1, 13'h1FFF, 1'b1);
      send_byte(8'hA5, 1'b0, 13'h1555, 1'b0);
      send_byte(8'h5A, 1'b1, 13'h1555, 1'b0);
      send_byte(8'h01, 1'b0, 13'h0123, 1'b0);
      send_byte(8'h02, 1'b0, 13'h0AAA, 1'b1);
      send_byte(8'h03, 1'b1, 13'h1F00, 1'b1);
      // adaptation field of length zero: only the length byte
      send_pes(MAX_ALEN, 13'h0AAA, 1'b1, 1'b0);
      // store fills exactly on the last beat: one full packet, no short one
      send_pes(PAYLOAD_BYTES, 13'h1555, 1'b0, 1'b0);
      send_byte(8'h80, 1'b1, 13'h0001, 1'b0);
      drain();

      run_random_phase(0, 0, PHASE_BYTES);
      run_random_phase(64, 0, PHASE_BYTES);
      run_random_phase(0, 64, PHASE_BYTES);
      run_random_phase(10, 10, PHASE_BYTES);

      // long output hold-off while the sender keeps offering beats; short PES
      // packets close both banks quickly so the input stalls
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      @(posedge clock);
      hold_cycles = HOLD_CYCLES;
      @(negedge clock);
      repeat (HOLD_PES) begin
         send_pes(HOLD_PES_LEN, 13'($urandom_range(8191)), 1'($urandom_range(1)), 1'b0);
      end
      drain();

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d PES beats and %0d TS words: %0d full packets, %0d short (%0d %s",
               sb.bytes_seen, sb.words_seen, sb.full_pkts, sb.short_pkts,
               sb.zero_alen_pkts, "with empty adaptation field)");
      $display("Idle/stall mixes plus a %0d-cycle output hold-off; input stalled %0d cycles",
               HOLD_CYCLES, input_stall_cycles);
      if (sb.errors == 0 && sb.ts_words_due.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
